// ===== src/fctc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame count / timecode converter package
// Shared constants, rate mode codes, register indexes and the item record.
// ----------------------------------------------------------------------------
package fctc_pkg;

   localparam int unsigned NumWidth = 32;
   localparam int unsigned DivSteps = NumWidth;

   localparam logic [2:0] MODE_NTSC_DF = 3'd0;
   localparam logic [2:0] MODE_PAL     = 3'd1;
   localparam logic [2:0] MODE_FILM_DF = 3'd2;
   localparam logic [2:0] MODE_HFR_DF  = 3'd3;

   localparam logic [1:0] CSR_RATE_MODE  = 2'd0;
   localparam logic [1:0] CSR_OTHER_FPH  = 2'd1;
   localparam logic [1:0] CSR_OTHER_FPM  = 2'd2;
   localparam logic [1:0] CSR_OTHER_FPS  = 2'd3;

   localparam logic [2:0]  RESET_RATE_MODE = MODE_NTSC_DF;
   localparam logic [18:0] RESET_OTHER_FPH = 19'd108000;
   localparam logic [12:0] RESET_OTHER_FPM = 13'd1800;
   localparam logic [6:0]  RESET_OTHER_FPS = 7'd30;

   localparam logic [31:0] MAX_HOURS   = 32'd65535;
   localparam logic [31:0] MAX_MINUTES = 32'd59;
   localparam logic [31:0] MAX_SECONDS = 32'd59;
   localparam logic [31:0] MAX_FRAME   = 32'd119;

   typedef struct packed {
      logic        opcode;
      logic        drop;
      logic [2:0]  skip;
      logic [18:0] ph;
      logic [18:0] pb;
      logic [11:0] pn;
      logic [11:0] pd;
      logic [6:0]  ps;
      logic [31:0] n;
      logic [31:0] count;
      logic        count_ovf;
      logic [31:0] hours;
      logic [31:0] minutes;
      logic        take;
      logic [31:0] rest;
   } item_type;

   function automatic logic [2:0] tens_of(input logic [5:0] m);
      logic [13:0] p;
      p = 14'(m) * 14'd205;
      return p[13:11];
   endfunction

endpackage
`default_nettype wire

// ===== src/fctc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Converter channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface fctc_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] frame_count_in;
   logic [15:0] hours_in;
   logic [5:0]  minutes_in;
   logic [5:0]  seconds_in;
   logic [6:0]  frame_in;
   modport source(output valid, opcode, frame_count_in, hours_in, minutes_in,
                  seconds_in, frame_in, input ready);
   modport sink(input valid, opcode, frame_count_in, hours_in, minutes_in,
                seconds_in, frame_in, output ready);
endinterface

interface fctc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] hours_out;
   logic [5:0]  minutes_out;
   logic [5:0]  seconds_out;
   logic [6:0]  frame_out;
   logic [31:0] frame_count_out;
   logic        overflow;
   modport source(output valid, hours_out, minutes_out, seconds_out, frame_out,
                  frame_count_out, overflow, input ready);
   modport sink(input valid, hours_out, minutes_out, seconds_out, frame_out,
                frame_count_out, overflow, output ready);
endinterface

interface fctc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/fctc_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; a zero divisor yields all ones and the dividend.
// ----------------------------------------------------------------------------
module fctc_divider
   import fctc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [NumWidth-1:0] in_num,
   input  wire logic [NumWidth-1:0] in_den,
   input  wire item_type            in_side,
   output logic                     out_valid,
   output logic [NumWidth-1:0]      out_quot,
   output logic [NumWidth-1:0]      out_rem,
   output item_type                 out_side
);

   logic                valid_ff [0:DivSteps];
   logic [NumWidth-1:0] num_ff   [0:DivSteps];
   logic [NumWidth-1:0] den_ff   [0:DivSteps];
   logic [NumWidth-1:0] rem_ff   [0:DivSteps];
   logic [NumWidth-1:0] quot_ff  [0:DivSteps];
   item_type            side_ff  [0:DivSteps];

   assign valid_ff[0] = in_valid;
   assign num_ff[0]   = in_num;
   assign den_ff[0]   = in_den;
   assign rem_ff[0]   = '0;
   assign quot_ff[0]  = '0;
   assign side_ff[0]  = in_side;

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      logic [NumWidth:0]   part;
      logic                ge;
      logic [NumWidth-1:0] rem_in;

      always_comb begin
         part   = {rem_ff[k], num_ff[k][NumWidth-1-k]};
         ge     = part >= {1'b0, den_ff[k]};
         rem_in = ge ? NumWidth'(part - {1'b0, den_ff[k]}) : part[NumWidth-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (en) begin
            num_ff[k+1]  <= num_ff[k];
            den_ff[k+1]  <= den_ff[k];
            rem_ff[k+1]  <= rem_in;
            quot_ff[k+1] <= {quot_ff[k][NumWidth-2:0], ge};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[DivSteps];
   assign out_quot  = quot_ff[DivSteps];
   assign out_rem   = rem_ff[DivSteps];
   assign out_side  = side_ff[DivSteps];

endmodule
`default_nettype wire

// ===== src/fctc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Converter front end
// Decode the rate constants and compute the timecode-to-count result.
// ----------------------------------------------------------------------------
module fctc_front
   import fctc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic        opcode,
   input  wire logic [31:0] frame_count,
   input  wire logic [15:0] hours,
   input  wire logic [5:0]  minutes,
   input  wire logic [5:0]  seconds,
   input  wire logic [6:0]  frame,
   input  wire logic [2:0]  mode,
   input  wire logic [18:0] other_fph,
   input  wire logic [12:0] other_fpm,
   input  wire logic [6:0]  other_fps,
   output logic             out_valid,
   output item_type         out_item
);

   item_type    item_in;
   logic [16:0] kt_in;
   logic [12:0] ku_in;
   logic [2:0]  mt_in;
   logic [3:0]  mu_in;

   logic        v0_ff, v1_ff, v2_ff;
   item_type    item0_ff, item1_ff, item2_ff;
   logic [15:0] h0_ff;
   logic [2:0]  mt0_ff;
   logic [3:0]  mu0_ff;
   logic [5:0]  s0_ff;
   logic [6:0]  f0_ff, f1_ff;
   logic [16:0] kt0_ff;
   logic [12:0] ku0_ff;
   logic [34:0] ph_prod_ff;
   logic [19:0] pt_prod_ff;
   logic [16:0] pu_prod_ff;
   logic [12:0] ps_prod_ff;
   logic [36:0] sum_in;
   item_type    item2_in;

   always_comb begin
      item_in        = '0;
      item_in.opcode = opcode;
      item_in.n      = frame_count;
      kt_in          = '0;
      ku_in          = '0;
      case (mode)
         MODE_NTSC_DF: begin
            item_in.drop = 1'b1;  item_in.skip = 3'd2;
            item_in.ph   = 19'd107892; item_in.pb = 19'd17982;
            item_in.pn   = 12'd1800;   item_in.pd = 12'd1798;
            item_in.ps   = 7'd30;
            kt_in = 17'd17982; ku_in = 13'd1798;
         end
         MODE_PAL: begin
            item_in.ph = 19'd90000; item_in.pb = 19'd1500; item_in.ps = 7'd25;
            kt_in = 17'd15000; ku_in = 13'd1500;
         end
         MODE_FILM_DF: begin
            item_in.drop = 1'b1;  item_in.skip = 3'd2;
            item_in.ph   = 19'd86292; item_in.pb = 19'd14382;
            item_in.pn   = 12'd1440;  item_in.pd = 12'd1438;
            item_in.ps   = 7'd24;
            kt_in = 17'd14382; ku_in = 13'd1438;
         end
         MODE_HFR_DF: begin
            item_in.drop = 1'b1;  item_in.skip = 3'd4;
            item_in.ph   = 19'd215784; item_in.pb = 19'd35964;
            item_in.pn   = 12'd3600;   item_in.pd = 12'd3596;
            item_in.ps   = 7'd60;
            kt_in = 17'd35964; ku_in = 13'd3596;
         end
         default: begin
            item_in.ph = other_fph;
            item_in.pb = 19'(other_fpm);
            item_in.ps = other_fps;
            kt_in = 17'(17'(other_fpm) * 17'd10);
            ku_in = other_fpm;
         end
      endcase
      mt_in = tens_of(minutes);
      mu_in = 4'(minutes - 6'(6'(mt_in) * 6'd10));
   end

   always_comb begin
      sum_in = 37'(ph_prod_ff) + 37'(pt_prod_ff) + 37'(pu_prod_ff)
             + 37'(ps_prod_ff) + 37'(f1_ff);
      item2_in           = item1_ff;
      item2_in.count_ovf = |sum_in[36:32];
      item2_in.count     = (|sum_in[36:32]) ? '1 : sum_in[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      if (en) begin
         item0_ff   <= item_in;
         h0_ff      <= hours;
         mt0_ff     <= mt_in;
         mu0_ff     <= mu_in;
         s0_ff      <= seconds;
         f0_ff      <= frame;
         kt0_ff     <= kt_in;
         ku0_ff     <= ku_in;
         item1_ff   <= item0_ff;
         ph_prod_ff <= 35'(h0_ff) * 35'(item0_ff.ph);
         pt_prod_ff <= 20'(mt0_ff) * 20'(kt0_ff);
         pu_prod_ff <= 17'(mu0_ff) * 17'(ku0_ff);
         ps_prod_ff <= 13'(s0_ff) * 13'(item0_ff.ps);
         f1_ff      <= f0_ff;
         item2_ff   <= item2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = item2_ff;

endmodule
`default_nettype wire

// ===== src/frame_count_timecode_converter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame count / timecode converter
// Converts a frame count to hours, minutes, seconds and frame, or back.
// ----------------------------------------------------------------------------
// One beat enters per clock while the response side keeps taking results, and
// results leave in order. The pipeline is made of four 32-stage restoring
// divider pipelines (hours, minutes, drop-frame minute, seconds) plus three
// front stages, two adjust stages and the output register. The
// whole pipeline holds while a finished result waits on the response side.
// Register writes are taken at any time and apply to beats entering after.
module frame_count_timecode_converter_unit
   import fctc_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   fctc_req_if.sink   req_bus,
   fctc_rsp_if.source rsp_bus,
   fctc_csr_if.sink   csr_bus
);

   logic        en;
   logic [2:0]  rate_mode_ff;
   logic [18:0] other_fph_ff;
   logic [12:0] other_fpm_ff;
   logic [6:0]  other_fps_ff;

   logic        fr_valid;
   item_type    fr_item;
   logic        da_valid, db_valid, dc_valid, dd_valid;
   logic [31:0] da_quot, da_rem, db_quot, db_rem, dc_quot, dc_rem, dd_quot, dd_rem;
   item_type    da_side, db_side, dc_side, dd_side;
   item_type    a_item, adj_item_in, fin_item_in;

   logic        adj_valid_ff, fin_valid_ff;
   item_type    adj_item_ff, fin_item_ff;

   logic        rsp_valid_ff;
   logic [15:0] hours_ff;
   logic [5:0]  minutes_ff, seconds_ff;
   logic [6:0]  frame_ff;
   logic [31:0] count_ff;
   logic        ovf_ff;

   logic        h_big, m_big, s_big, f_big;

   assign en            = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_mode_ff <= RESET_RATE_MODE;
         other_fph_ff <= RESET_OTHER_FPH;
         other_fpm_ff <= RESET_OTHER_FPM;
         other_fps_ff <= RESET_OTHER_FPS;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_RATE_MODE: rate_mode_ff <= csr_bus.data[2:0];
            CSR_OTHER_FPH: other_fph_ff <= csr_bus.data[18:0];
            CSR_OTHER_FPM: other_fpm_ff <= csr_bus.data[12:0];
            CSR_OTHER_FPS: other_fps_ff <= csr_bus.data[6:0];
            default: ;
         endcase
      end
   end

   fctc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_bus.valid),
      .opcode      (req_bus.opcode),
      .frame_count (req_bus.frame_count_in),
      .hours       (req_bus.hours_in),
      .minutes     (req_bus.minutes_in),
      .seconds     (req_bus.seconds_in),
      .frame       (req_bus.frame_in),
      .mode        (rate_mode_ff),
      .other_fph   (other_fph_ff),
      .other_fpm   (other_fpm_ff),
      .other_fps   (other_fps_ff),
      .out_valid   (fr_valid),
      .out_item    (fr_item)
   );

   fctc_divider u_div_hours (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (fr_valid), .in_num (fr_item.n), .in_den (32'(fr_item.ph)),
      .in_side (fr_item),
      .out_valid (da_valid), .out_quot (da_quot), .out_rem (da_rem),
      .out_side (da_side)
   );

   always_comb begin
      a_item       = da_side;
      a_item.hours = da_quot;
      a_item.rest  = da_rem;
   end

   fctc_divider u_div_minutes (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (da_valid), .in_num (da_rem), .in_den (32'(da_side.pb)),
      .in_side (a_item),
      .out_valid (db_valid), .out_quot (db_quot), .out_rem (db_rem),
      .out_side (db_side)
   );

   always_comb begin
      adj_item_in         = db_side;
      adj_item_in.minutes = db_side.drop ? 32'(db_quot * 32'd10) : db_quot;
      adj_item_in.take    = db_side.drop && (db_rem >= 32'(db_side.pn));
      adj_item_in.rest    = adj_item_in.take ? 32'(db_rem - 32'(db_side.pn)) : db_rem;
   end

   fctc_divider u_div_short (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (adj_valid_ff), .in_num (adj_item_ff.rest),
      .in_den (32'(adj_item_ff.pd)), .in_side (adj_item_ff),
      .out_valid (dc_valid), .out_quot (dc_quot), .out_rem (dc_rem),
      .out_side (dc_side)
   );

   always_comb begin
      fin_item_in = dc_side;
      if (dc_side.take) begin
         fin_item_in.minutes = 32'(dc_side.minutes + 32'd1 + dc_quot);
         fin_item_in.rest    = 32'(dc_rem + 32'(dc_side.skip));
      end
   end

   fctc_divider u_div_seconds (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (fin_valid_ff), .in_num (fin_item_ff.rest),
      .in_den (32'(fin_item_ff.ps)), .in_side (fin_item_ff),
      .out_valid (dd_valid), .out_quot (dd_quot), .out_rem (dd_rem),
      .out_side (dd_side)
   );

   always_comb begin
      h_big = dd_side.hours   > MAX_HOURS;
      m_big = dd_side.minutes > MAX_MINUTES;
      s_big = dd_quot         > MAX_SECONDS;
      f_big = dd_rem          > MAX_FRAME;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adj_valid_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         adj_valid_ff <= db_valid;
         fin_valid_ff <= dc_valid;
         rsp_valid_ff <= dd_valid;
      end
      if (en) begin
         adj_item_ff <= adj_item_in;
         fin_item_ff <= fin_item_in;
         if (dd_side.opcode) begin
            hours_ff   <= '0;
            minutes_ff <= '0;
            seconds_ff <= '0;
            frame_ff   <= '0;
            count_ff   <= dd_side.count;
            ovf_ff     <= dd_side.count_ovf;
         end else begin
            hours_ff   <= h_big ? MAX_HOURS[15:0]  : dd_side.hours[15:0];
            minutes_ff <= m_big ? MAX_MINUTES[5:0] : dd_side.minutes[5:0];
            seconds_ff <= s_big ? MAX_SECONDS[5:0] : dd_quot[5:0];
            frame_ff   <= f_big ? MAX_FRAME[6:0]   : dd_rem[6:0];
            count_ff   <= '0;
            ovf_ff     <= h_big || m_big || s_big || f_big;
         end
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.hours_out       = hours_ff;
   assign rsp_bus.minutes_out     = minutes_ff;
   assign rsp_bus.seconds_out     = seconds_ff;
   assign rsp_bus.frame_out       = frame_ff;
   assign rsp_bus.frame_count_out = count_ff;
   assign rsp_bus.overflow        = ovf_ff;

endmodule
`default_nettype wire
